// ----- rtl/nonpreemptive_job_scheduler_defines.svh -----
// Assertion macros for the job scheduler checker.
`ifndef NONPREEMPTIVE_JOB_SCHEDULER_DEFINES_SVH
`define NONPREEMPTIVE_JOB_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define NJS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nonpreemptive_job_scheduler: check failed");

// Next-cycle implication, disabled in reset.
`define NJS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nonpreemptive_job_scheduler: check failed");

// Next-cycle implication that also holds through reset.
`define NJS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("nonpreemptive_job_scheduler: check failed");

`endif

// ----- rtl/njs_pkg.sv -----
package njs_pkg;

  localparam int FIELD_W       = 16;
  localparam int JOB_W         = 3 * FIELD_W;
  localparam int TAT_W         = 20;
  localparam int SUM_W         = 23;
  localparam int IDX_OUT_W     = 3;
  localparam int IN_TDATA_W    = 48;
  localparam int OUT_PAYLOAD_W = IDX_OUT_W + 2 * TAT_W + 2 * SUM_W;
  localparam int OUT_TDATA_W   = 96;

  localparam logic POLICY_SJF  = 1'b0;
  localparam logic POLICY_PRIO = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_COMMIT,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic scan_init;
    logic scan_step;
    logic decide;
    logic commit;
    logic emit_phase;
    logic emit_load;
    logic run_clear;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic sel_found;
    logic sel_last;
    logic emit_last;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/njs_ram.sv -----
module njs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/njs_ctrl.sv -----
module njs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  input  logic          in_tlast,
  output logic          in_tready,
  input  njs_pkg::sts_t sts,
  output njs_pkg::cmd_t cmd
);
  import njs_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = in_tvalid && (state_r == ST_LOAD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept && in_tlast) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_nxt = sts.sel_found ? ST_COMMIT : ST_SCAN;
      end
      ST_COMMIT: begin
        state_nxt = sts.sel_last ? ST_EMIT_RD : ST_SCAN;
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (sts.out_free) state_nxt = sts.emit_last ? ST_LOAD : ST_EMIT_RD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready     = 1'b1;
        cmd.load      = accept;
        cmd.scan_init = accept && in_tlast;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_DECIDE: begin
        cmd.decide    = 1'b1;
        cmd.scan_init = !sts.sel_found;
      end
      ST_COMMIT: begin
        cmd.commit     = 1'b1;
        cmd.scan_init  = !sts.sel_last;
        cmd.emit_phase = sts.sel_last;
      end
      ST_EMIT_RD: begin
        cmd.emit_phase = 1'b1;
      end
      ST_EMIT_OUT: begin
        cmd.emit_phase = 1'b1;
        cmd.emit_load  = sts.out_free;
        cmd.run_clear  = sts.out_free && sts.emit_last;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/njs_dp.sv -----
module njs_dp #(
  parameter int MAX_JOBS = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  njs_pkg::cmd_t                      cmd,
  output njs_pkg::sts_t                      sts,
  input  logic [njs_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  logic                               cfg_wr_en,
  input  logic                               cfg_wr_data,
  input  logic                               out_tready,
  output logic                               out_tvalid,
  output logic [njs_pkg::OUT_TDATA_W-1:0]    out_tdata,
  output logic                               out_tlast
);
  import njs_pkg::*;

  localparam int IDX_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CNT_W  = $clog2(MAX_JOBS + 1);
  localparam int TICK_W = FIELD_W + CNT_W;

  logic                     policy_r;
  logic [CNT_W-1:0]         loaded_r;
  logic [CNT_W-1:0]         done_r;
  logic [TICK_W-1:0]        tick_r;
  logic [MAX_JOBS-1:0]      fin_r;
  logic [IDX_W-1:0]         scan_idx_r;
  logic                     cmp_vld_r;
  logic [IDX_W-1:0]         cmp_idx_r;
  logic                     found_r;
  logic [FIELD_W-1:0]       best_key_r;
  logic [IDX_W-1:0]         best_idx_r;
  logic [FIELD_W-1:0]       best_arr_r;
  logic [FIELD_W-1:0]       best_burst_r;
  logic [FIELD_W-1:0]       min_arr_r;
  logic [IDX_W-1:0]         emit_idx_r;
  logic [SUM_W-1:0]         sum_tat_r;
  logic [SUM_W-1:0]         sum_wt_r;
  logic                     out_valid_r;
  logic [OUT_PAYLOAD_W-1:0] out_data_r;
  logic                     out_last_r;

  logic                     job_we;
  logic [IDX_W-1:0]         job_raddr;
  logic [JOB_W-1:0]         job_rd;
  logic [TICK_W-1:0]        tat_rd;
  logic [TICK_W-1:0]        tat_wdata;
  logic [FIELD_W-1:0]       rd_arr;
  logic [FIELD_W-1:0]       rd_burst;
  logic [FIELD_W-1:0]       rd_pri;
  logic [FIELD_W-1:0]       key;
  logic                     pending;
  logic                     take;
  logic                     lower_arr;
  logic [TICK_W-1:0]        wt;
  logic [SUM_W-1:0]         sum_tat_nxt;
  logic [SUM_W-1:0]         sum_wt_nxt;
  logic [SUM_W-1:0]         tot_tat;
  logic [SUM_W-1:0]         tot_wt;

  assign job_we    = cmd.load && (loaded_r < CNT_W'(MAX_JOBS));
  assign job_raddr = cmd.emit_phase ? emit_idx_r : scan_idx_r;
  assign tat_wdata = tick_r - TICK_W'(best_arr_r);

  njs_ram #(.WIDTH(JOB_W), .DEPTH(MAX_JOBS)) u_job_ram (
    .clk   (clk),
    .we    (job_we),
    .waddr (loaded_r[IDX_W-1:0]),
    .wdata (in_tdata[JOB_W-1:0]),
    .raddr (job_raddr),
    .rdata (job_rd)
  );

  njs_ram #(.WIDTH(TICK_W), .DEPTH(MAX_JOBS)) u_tat_ram (
    .clk   (clk),
    .we    (cmd.commit),
    .waddr (best_idx_r),
    .wdata (tat_wdata),
    .raddr (emit_idx_r),
    .rdata (tat_rd)
  );

  assign rd_arr   = job_rd[FIELD_W-1:0];
  assign rd_burst = job_rd[2*FIELD_W-1:FIELD_W];
  assign rd_pri   = job_rd[3*FIELD_W-1:2*FIELD_W];

  // selection compare, one entry per cycle
  always_comb begin
    key       = (policy_r == POLICY_PRIO) ? rd_pri : rd_burst;
    pending   = cmp_vld_r && !fin_r[cmp_idx_r];
    take      = pending && (TICK_W'(rd_arr) <= tick_r) && (!found_r || key < best_key_r);
    lower_arr = pending && (rd_arr < min_arr_r);
  end

  always_comb begin
    wt          = tat_rd - TICK_W'(rd_burst);
    sum_tat_nxt = sum_tat_r + SUM_W'(tat_rd);
    sum_wt_nxt  = sum_wt_r + SUM_W'(wt);
    tot_tat     = sts.emit_last ? sum_tat_nxt : '0;
    tot_wt      = sts.emit_last ? sum_wt_nxt : '0;
  end

  always_comb begin
    sts.scan_last = (CNT_W'(scan_idx_r) + CNT_W'(1)) == loaded_r;
    sts.sel_found = found_r;
    sts.sel_last  = (done_r + CNT_W'(1)) == loaded_r;
    sts.emit_last = (CNT_W'(emit_idx_r) + CNT_W'(1)) == loaded_r;
    sts.out_free  = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r    <= POLICY_SJF;
      loaded_r    <= '0;
      done_r      <= '0;
      tick_r      <= '0;
      fin_r       <= '0;
      cmp_vld_r   <= 1'b0;
      emit_idx_r  <= '0;
      sum_tat_r   <= '0;
      sum_wt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) policy_r <= cfg_wr_data;
      if (job_we) loaded_r <= loaded_r + CNT_W'(1);
      cmp_vld_r <= cmd.scan_step;
      if (cmd.decide) begin
        tick_r <= found_r ? tick_r + TICK_W'(best_burst_r) : TICK_W'(min_arr_r);
      end
      if (cmd.commit) begin
        fin_r[best_idx_r] <= 1'b1;
        done_r            <= done_r + CNT_W'(1);
      end
      if (cmd.run_clear) begin
        emit_idx_r <= '0;
        sum_tat_r  <= '0;
        sum_wt_r   <= '0;
      end else if (cmd.emit_load) begin
        emit_idx_r <= emit_idx_r + IDX_W'(1);
        sum_tat_r  <= sum_tat_nxt;
        sum_wt_r   <= sum_wt_nxt;
      end
      if (cmd.emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.run_clear) begin
        loaded_r <= '0;
        done_r   <= '0;
        tick_r   <= '0;
        fin_r    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_idx_r <= '0;
      found_r    <= 1'b0;
      min_arr_r  <= '1;
    end else if (cmd.scan_step) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
    end
    cmp_idx_r <= scan_idx_r;
    if (take) begin
      found_r      <= 1'b1;
      best_key_r   <= key;
      best_idx_r   <= cmp_idx_r;
      best_arr_r   <= rd_arr;
      best_burst_r <= rd_burst;
    end
    if (lower_arr) min_arr_r <= rd_arr;
    if (cmd.emit_load) begin
      out_data_r <= {tot_wt, tot_tat, TAT_W'(wt), TAT_W'(tat_rd), IDX_OUT_W'(emit_idx_r)};
      out_last_r <= sts.emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);
  assign out_tlast  = out_last_r;

endmodule

// ----- rtl/nonpreemptive_job_scheduler.sv -----
// Non-preemptive job scheduler. Jobs are loaded one per cycle (arrival, burst,
// priority); in_tlast closes the set and starts the run, and jobs beyond MAX_JOBS
// are dropped. cfg_wr_data selects shortest burst first (0) or lowest priority
// number first (1); write it only between runs. Every selection is one pass
// over the job memory (read pipeline, decide, completion write), and an
// idle-time jump costs one extra pass. One result per job then follows in load
// order, each read from memory and then loaded into the output register once
// it is free; the last carries the totals and tlast. in_tready drops from the
// final load until the last result has entered the output register. No
// clearing pass is needed after reset.
module nonpreemptive_job_scheduler #(
  parameter int MAX_JOBS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // arrival_time, burst_time, priority_value
  input  logic [njs_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // job_index, turnaround, waiting, total_turnaround, total_waiting, zero pad
  output logic [njs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tlast,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_wr_data
);
  import njs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  njs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  njs_dp #(.MAX_JOBS(MAX_JOBS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

// ----- rtl/njs_checker.sv -----
`include "nonpreemptive_job_scheduler_defines.svh"

module njs_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [njs_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tlast
);

  // closing request starts the run: no further load right after it
  `NJS_ASSERT_NEXT(a_run_blocks_load, clk, rst_n, in_tvalid && in_tready && in_tlast, !in_tready)

  // results of an unfinished run keep the input closed
  `NJS_ASSERT_IMPLY(a_emit_blocks_load, clk, rst_n, out_tvalid && !out_tlast, !in_tready)

  `NJS_ASSERT_NEXT_ALWAYS(a_reset_clears_out, clk, !rst_n, !out_tvalid)

  `NJS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind nonpreemptive_job_scheduler njs_checker u_njs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

// ----- tb/sv/tb_nonpreemptive_job_scheduler.sv -----
module tb_nonpreemptive_job_scheduler;
  import njs_pkg::*;

  localparam int MAX_JOBS    = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN       = 16;
  localparam int LIMIT       = 400000;
  localparam int PHASE_ITEMS = 60;
  localparam int NUM_ROWS    = 23;

  typedef struct packed {
    logic [2:0]  idx;
    logic [19:0] tat;
    logic [19:0] wt;
    logic [22:0] tat_sum;
    logic [22:0] wt_sum;
    logic        last;
  } job_result_t;

  typedef struct packed {
    logic [15:0] arr;
    logic [15:0] bur;
    logic [15:0] pri;
    logic        last;
    logic        pol;
    logic        typed;
    logic [19:0] tat;
    logic [19:0] wt;
  } stim_row_t;

  logic                   clk         = 1'b0;
  logic                   rst_n       = 1'b0;
  logic                   in_tvalid   = 1'b0;
  logic                   in_tready;
  // arrival_time, burst_time, priority_value
  logic [IN_TDATA_W-1:0]  in_tdata    = '0;
  logic                   in_tlast    = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready  = 1'b0;
  // job_index, turnaround, waiting, total_turnaround, total_waiting, pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_wr_en   = 1'b0;
  logic                   cfg_wr_data = 1'b0;

  logic [15:0] pend_arr [MAX_JOBS];
  logic [15:0] pend_bur [MAX_JOBS];
  logic [15:0] pend_pri [MAX_JOBS];
  int          pend_count = 0;
  logic        policy     = POLICY_SJF;

  job_result_t due_results [$];
  job_result_t head;

  int errors     = 0;
  int cycles     = 0;
  int items      = 0;
  int tx_idle    = 0;
  int rx_idle    = 0;
  int hold_token = 0;
  int hold_seen  = 0;
  int hold_left  = 0;

  stim_row_t directed [NUM_ROWS] = '{
    '{16'd0,     16'd5,     16'd0,     1'b1, POLICY_SJF,  1'b1, 20'd5,     20'd0},
    '{16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b1, POLICY_SJF,  1'b1, 20'd65535, 20'd0},
    '{16'd0,     16'd0,     16'd0,     1'b1, POLICY_SJF,  1'b1, 20'd0,     20'd0},
    '{16'd0,     16'd8,     16'd1,     1'b0, POLICY_SJF,  1'b0, 20'd0,     20'd0},
    '{16'd1,     16'd4,     16'd2,     1'b0, POLICY_SJF,  1'b0, 20'd0,     20'd0},
    '{16'd2,     16'd4,     16'd0,     1'b1, POLICY_SJF,  1'b0, 20'd0,     20'd0},
    '{16'd100,   16'd3,     16'd0,     1'b0, POLICY_SJF,  1'b0, 20'd0,     20'd0},
    '{16'd10,    16'd2,     16'd5,     1'b1, POLICY_SJF,  1'b0, 20'd0,     20'd0},
    '{16'd0,     16'hFFFF,  16'd7,     1'b0, POLICY_SJF,  1'b0, 20'd0,     20'd0},
    '{16'd0,     16'hFFFF,  16'd6,     1'b0, POLICY_SJF,  1'b0, 20'd0,     20'd0},
    '{16'd0,     16'hFFFF,  16'd5,     1'b0, POLICY_SJF,  1'b0, 20'd0,     20'd0},
    '{16'd0,     16'hFFFF,  16'd4,     1'b0, POLICY_SJF,  1'b0, 20'd0,     20'd0},
    '{16'd0,     16'hFFFF,  16'd3,     1'b0, POLICY_SJF,  1'b0, 20'd0,     20'd0},
    '{16'd0,     16'hFFFF,  16'd2,     1'b0, POLICY_SJF,  1'b0, 20'd0,     20'd0},
    '{16'd0,     16'hFFFF,  16'd1,     1'b0, POLICY_SJF,  1'b0, 20'd0,     20'd0},
    '{16'd0,     16'hFFFF,  16'd0,     1'b0, POLICY_SJF,  1'b0, 20'd0,     20'd0},
    '{16'd5,     16'd1,     16'd0,     1'b0, POLICY_SJF,  1'b0, 20'd0,     20'd0},
    '{16'd9,     16'd9,     16'd9,     1'b1, POLICY_SJF,  1'b0, 20'd0,     20'd0},
    '{16'd0,     16'd10,    16'd3,     1'b0, POLICY_PRIO, 1'b0, 20'd0,     20'd0},
    '{16'd0,     16'd1,     16'd3,     1'b0, POLICY_PRIO, 1'b0, 20'd0,     20'd0},
    '{16'd0,     16'd5,     16'd1,     1'b1, POLICY_PRIO, 1'b0, 20'd0,     20'd0},
    '{16'hFFFF,  16'd0,     16'hFFFF,  1'b1, POLICY_PRIO, 1'b1, 20'd0,     20'd0},
    '{16'd0,     16'hFFFF,  16'd0,     1'b1, POLICY_PRIO, 1'b1, 20'd65535, 20'd0}
  };

  nonpreemptive_job_scheduler #(.MAX_JOBS(MAX_JOBS)) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic flag_mismatch(string what, logic [22:0] want, logic [22:0] got);
    errors++;
    $display("mismatch %s: expected %0d got %0d", what, want, got);
  endtask

  // non-preemptive run over the pending set, results in load order
  function automatic void schedule_jobs(output job_result_t res [MAX_JOBS], output int n);
    longint unsigned tick;
    longint unsigned next_arr;
    longint unsigned tat_sum;
    longint unsigned wt_sum;
    longint unsigned wt;
    longint unsigned tat [MAX_JOBS];
    bit              done [MAX_JOBS];
    int              left;
    int              pick;
    bit              found;
    logic [15:0]     key;
    logic [15:0]     best;
    n       = pend_count;
    tick    = 0;
    left    = n;
    tat_sum = 0;
    wt_sum  = 0;
    for (int i = 0; i < MAX_JOBS; i++) begin
      done[i] = 1'b0;
      tat[i]  = 0;
    end
    while (left > 0) begin
      found = 1'b0;
      pick  = 0;
      best  = '0;
      for (int i = 0; i < n; i++) begin
        if (done[i] || pend_arr[i] > tick) continue;
        key = (policy == POLICY_PRIO) ? pend_pri[i] : pend_bur[i];
        if (!found || key < best) begin
          found = 1'b1;
          best  = key;
          pick  = i;
        end
      end
      if (found) begin
        tick      += pend_bur[pick];
        tat[pick] = tick - pend_arr[pick];
        done[pick] = 1'b1;
        left--;
      end else begin
        next_arr = '1;
        for (int i = 0; i < n; i++)
          if (!done[i] && pend_arr[i] < next_arr) next_arr = pend_arr[i];
        tick = next_arr;
      end
    end
    for (int i = 0; i < n; i++) begin
      wt         = tat[i] - pend_bur[i];
      tat_sum   += tat[i];
      wt_sum    += wt;
      res[i].idx  = 3'(i);
      res[i].tat  = 20'(tat[i]);
      res[i].wt   = 20'(wt);
      res[i].last = (i == n - 1);
      res[i].tat_sum = res[i].last ? 23'(tat_sum) : 23'd0;
      res[i].wt_sum  = res[i].last ? 23'(wt_sum) : 23'd0;
    end
  endfunction

  task automatic send_job(input logic [15:0] arr, input logic [15:0] bur,
                          input logic [15:0] pri, input logic last, input logic typed,
                          input logic [19:0] tat, input logic [19:0] wt);
    job_result_t res [MAX_JOBS];
    job_result_t one;
    int          n;
    while ($urandom_range(99) < tx_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {pri, bur, arr};
    in_tlast  <= last;
    do @(posedge clk); while (in_tready !== 1'b1);
    if (pend_count < MAX_JOBS) begin
      pend_arr[pend_count] = arr;
      pend_bur[pend_count] = bur;
      pend_pri[pend_count] = pri;
      pend_count++;
    end
    if (last) begin
      if (typed) begin
        one = '{3'd0, tat, wt, 23'(tat), 23'(wt), 1'b1};
        due_results.push_back(one);
      end else begin
        schedule_jobs(res, n);
        for (int i = 0; i < n; i++) due_results.push_back(res[i]);
      end
      pend_count = 0;
    end
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic write_policy(input logic value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    policy = value;
  endtask

  // well-formed sets mostly, some overfilled past MAX_JOBS
  task automatic send_random_set();
    int          n;
    int          mode;
    logic [15:0] arr;
    logic [15:0] bur;
    logic [15:0] pri;
    n    = ($urandom_range(9) == 0) ? $urandom_range(11, 9) : $urandom_range(8, 1);
    mode = $urandom_range(3);
    for (int k = 0; k < n; k++) begin
      arr = mode[0] ? 16'($urandom_range(65535)) : 16'($urandom_range(40));
      if ($urandom_range(7) == 0) bur = '0;
      else bur = mode[1] ? 16'($urandom_range(65535)) : 16'($urandom_range(20));
      pri = ($urandom_range(3) == 0) ? 16'($urandom_range(3)) : 16'($urandom_range(65535));
      send_job(arr, bur, pri, k == n - 1, 1'b0, '0, '0);
      if (k < MAX_JOBS) items++;
    end
  endtask

  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (due_results.size() == 0) begin
        flag_mismatch("result with none pending, job_index", '0, 23'(out_tdata[2:0]));
      end else begin
        head = due_results.pop_front();
        if (out_tdata[2:0] !== head.idx)
          flag_mismatch("job_index", 23'(head.idx), 23'(out_tdata[2:0]));
        if (out_tdata[22:3] !== head.tat)
          flag_mismatch("turnaround", 23'(head.tat), 23'(out_tdata[22:3]));
        if (out_tdata[42:23] !== head.wt)
          flag_mismatch("waiting", 23'(head.wt), 23'(out_tdata[42:23]));
        if (out_tdata[65:43] !== head.tat_sum)
          flag_mismatch("total_turnaround", head.tat_sum, out_tdata[65:43]);
        if (out_tdata[88:66] !== head.wt_sum)
          flag_mismatch("total_waiting", head.wt_sum, out_tdata[88:66]);
        if (out_tlast !== head.last)
          flag_mismatch("last_result", 23'(head.last), 23'(out_tlast));
      end
    end
  end

  initial begin
    int target;
    repeat (9) @(posedge clk);
    rst_n   <= 1'b1;
    tx_idle =  24;
    rx_idle <= 67;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++) begin
      if (pend_count == 0 && directed[r].pol != policy) begin
        wait_idle();
        write_policy(directed[r].pol);
      end
      send_job(directed[r].arr, directed[r].bur, directed[r].pri, directed[r].last,
               directed[r].typed, directed[r].tat, directed[r].wt);
    end

    for (int ph = 0; ph < 3; ph++) begin
      for (int half = 0; half < 2; half++) begin
        wait_idle();
        if (half == 0) begin
          tx_idle =  (ph == 0) ? 24 : (ph == 1) ? 67 : 0;
          rx_idle <= (ph == 0) ? 67 : (ph == 1) ? 24 : 0;
        end
        write_policy(half == 0 ? POLICY_SJF : POLICY_PRIO);
        if (ph == 2 && half == 0) hold_token <= hold_token + 1;
        target = items + PHASE_ITEMS;
        while (items < target) send_random_set();
      end
    end

    wait_idle();
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/njs_pkg.sv
rtl/njs_ram.sv
rtl/njs_ctrl.sv
rtl/njs_dp.sv
rtl/nonpreemptive_job_scheduler.sv
rtl/njs_checker.sv
tb/sv/tb_nonpreemptive_job_scheduler.sv
